@@ sv/zse_pkg.sv @@
package zse_pkg;

    // depth of the group queue between packer and converter
    localparam int unsigned QUEUE_DEPTH = 2;

    // w / 85 == (w * DIV85_MUL) >> DIV85_SHIFT, exact for every 32-bit w
    localparam logic [31:0] DIV85_MUL   = 32'd3233857729;
    localparam int unsigned DIV85_SHIFT = 38;
    localparam int unsigned QUOT_W      = 64 - DIV85_SHIFT;

    // digit alphabet, first character in the top byte
    localparam logic [85*8-1:0] ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    typedef struct packed {
        logic [6:0] code_char;
        logic       last_char;
    } char_req_t;

    // one packed group waiting for conversion
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } group_t;

    // converted group, digits[4] is the most significant digit
    typedef struct packed {
        logic [4:0][6:0] digits;
        logic [2:0]      count;
        logic            last;
    } digits_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [6:0] z85_char(input logic [6:0] digit);
        logic [6:0] pos;
        pos = 7'd84 - digit;
        return ALPHABET[{pos, 3'b000} +: 7];
    endfunction

endpackage

@@ sv/zse_front.sv @@
module zse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  zse_pkg::byte_req_t  byte_data,
    input  zse_pkg::queue_stat_t q_stat,
    output logic                push,
    output zse_pkg::group_t     push_data
);

    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic [31:0] merged;
    logic        accept;
    logic        finish;

    assign byte_stall = q_stat.full;
    assign accept     = byte_valid && !q_stat.full;
    assign finish     = (fill_reg == 2'd3) || byte_data.last_byte;
    assign push       = accept && finish;

    // big-endian lane for the incoming byte
    always_comb
    begin
        unique case (fill_reg)
            2'd0: merged = word_reg | {byte_data.data_byte, 24'd0};
            2'd1: merged = word_reg | {8'd0, byte_data.data_byte, 16'd0};
            2'd2: merged = word_reg | {16'd0, byte_data.data_byte, 8'd0};
            default: merged = word_reg | {24'd0, byte_data.data_byte};
        endcase
    end

    always_comb
    begin
        push_data.word  = merged;
        push_data.count = (fill_reg == 2'd3) ? 3'd5 : ({1'b0, fill_reg} + 3'd2);
        push_data.last  = byte_data.last_byte;
    end

    always_comb
    begin
        word_next = word_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (finish)
            begin
                word_next = '0;
                fill_next = '0;
            end
            else
            begin
                word_next = merged;
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ sv/zse_queue.sv @@
module zse_queue #(
    parameter int unsigned DEPTH = zse_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  zse_pkg::group_t      push_data,
    input  logic                 pop,
    output zse_pkg::group_t      head,
    output zse_pkg::queue_stat_t q_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    zse_pkg::group_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/zse_conv.sv @@
module zse_conv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  zse_pkg::group_t      head,
    input  zse_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 load,
    output zse_pkg::digits_t     load_data,
    input  logic                 load_ready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_REM  = 3'b100
    } conv_state_t;

    localparam int unsigned QW = zse_pkg::QUOT_W;

    conv_state_t     state_reg;
    conv_state_t     state_next;
    logic [31:0]     word_reg;
    logic [31:0]     word_next;
    logic [QW-1:0]   quot_reg;
    logic [QW-1:0]   quot_next;
    logic [1:0]      step_reg;
    logic [1:0]      step_next;
    logic [2:0][6:0] work_reg;
    logic [2:0][6:0] work_next;
    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic            last_reg;
    logic            last_next;

    logic [63:0]     product;
    logic [31:0]     quot85;
    logic [31:0]     rem_full;
    logic [6:0]      rem;
    logic            final_step;
    logic            start;

    assign product  = 64'(word_reg) * 64'(zse_pkg::DIV85_MUL);
    assign quot85   = (32'(quot_reg) << 6) + (32'(quot_reg) << 4)
                    + (32'(quot_reg) << 2) + 32'(quot_reg);
    assign rem_full = word_reg - quot85;
    assign rem      = rem_full[6:0];

    assign final_step = (state_reg == S_REM) && (step_reg == 2'd3);
    assign load       = final_step && load_ready;
    assign start      = !q_stat.empty && ((state_reg == S_IDLE) || load);
    assign pop        = start;

    // last quotient is already below 85 and is the leading digit
    always_comb
    begin
        load_data.digits = {quot_reg[6:0], rem, work_reg[2], work_reg[1], work_reg[0]};
        load_data.count  = count_reg;
        load_data.last   = last_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        work_next  = work_reg;
        count_next = count_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                quot_next  = product[63 -: QW];
                state_next = S_REM;
            end
            S_REM:
            begin
                if (!final_step)
                begin
                    work_next  = {rem, work_reg[2:1]};
                    word_next  = 32'(quot_reg);
                    step_next  = step_reg + 2'd1;
                    state_next = S_MUL;
                end
                else if (load)
                begin
                    state_next = start ? S_MUL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (start)
        begin
            word_next  = head.word;
            count_next = head.count;
            last_next  = head.last;
            step_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        quot_reg  <= quot_next;
        work_reg  <= work_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ sv/zse_emit.sv @@
module zse_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  zse_pkg::digits_t   load_data,
    output logic               load_ready,
    output logic               char_valid,
    input  logic               char_stall,
    output zse_pkg::char_req_t char_data
);

    logic            valid_reg;
    logic            valid_next;
    logic [4:0][6:0] digits_reg;
    logic [4:0][6:0] digits_next;
    logic [2:0]      left_reg;
    logic [2:0]      left_next;
    logic            last_reg;
    logic            last_next;
    logic            accept;
    logic            final_char;

    assign accept     = valid_reg && !char_stall;
    assign final_char = (left_reg == 3'd1);
    assign load_ready = !valid_reg || (accept && final_char);

    assign char_valid          = valid_reg;
    assign char_data.code_char = zse_pkg::z85_char(digits_reg[4]);
    assign char_data.last_char = last_reg && final_char;

    always_comb
    begin
        valid_next  = valid_reg;
        digits_next = digits_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            digits_next = load_data.digits;
            left_next   = load_data.count;
            last_next   = load_data.last;
        end
        else if (accept)
        begin
            if (final_char)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                digits_next = {digits_reg[3:0], 7'd0};
                left_next   = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ sv/z85_stream_encoder.sv @@
// z85 stream encoder: bytes come in one request at a time on the byte channel, with
// last_byte on the final byte of a stream; every four bytes are packed big-endian and
// leave as five z85 characters, leading base-85 digit first, one character per request
// on the char channel; a short final group of k bytes is zero-padded and gives k+1
// characters, and last_char marks the final character of the stream. a packer takes a
// byte every cycle while the group queue has room; a converter then splits each group
// with one 32x32 reciprocal multiplier and four divide-by-85 steps, each a multiply state
// and a remainder state, whatever the group's length, so the converter sets the sustained
// input rate; characters leave at one per cycle from the output stage when char_stall
// is low, while the next group is converted. a byte that closes a group passes the
// queue, the converter states and the output stage register before its first character
module z85_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = zse_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    // byte requests
    input  logic               byte_valid,
    output logic               byte_stall,
    input  zse_pkg::byte_req_t byte_data,
    // character requests
    output logic               char_valid,
    input  logic               char_stall,
    output zse_pkg::char_req_t char_data
);

    // packer to queue
    logic                 push;
    zse_pkg::group_t      push_data;
    zse_pkg::queue_stat_t q_stat;

    // queue to converter
    logic                 pop;
    zse_pkg::group_t      head;

    // converter to output stage
    logic                 load;
    logic                 load_ready;
    zse_pkg::digits_t     load_data;

    // front: packs bytes into groups
    zse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    // short queue so the packer keeps taking bytes while a group converts
    zse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // back: iterative divide by 85
    zse_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .load       (load),
        .load_data  (load_data),
        .load_ready (load_ready)
    );

    // output stage: one character per request
    zse_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_data  (load_data),
        .load_ready (load_ready),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    // a group is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_stat.full))
        else $error("group pushed into full queue");

    // a group is never popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && q_stat.empty))
        else $error("group popped from empty queue");

    // a converted group always carries two to five characters
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (load_data.count >= 3'd2 && load_data.count <= 3'd5))
        else $error("bad character count on converted group");

    // a short group is pushed only at the end of a stream, with the last flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.count != 3'd5) |-> push_data.last)
        else $error("short group pushed without last flag");

endmodule
